>>> src/kcu_pkg.sv
// Shared types and constants for the KeeLoq cipher unit.
`default_nettype none

package kcu_pkg;

  typedef enum logic [1:0] {
    REQ_ENCRYPT = 2'd0,
    REQ_DECRYPT = 2'd1,
    REQ_LEARN   = 2'd2,
    REQ_RSVD    = 2'd3
  } req_type_t;

  // Register indexes on the configuration port
  typedef enum logic {
    CFG_MFR_KEY = 1'b0,
    CFG_NLF     = 1'b1
  } cfg_reg_t;

  localparam int KEY_W  = 64;
  localparam int WORD_W = 32;
  localparam int NLF_W  = 32;

  localparam logic [KEY_W-1:0]  MFR_KEY_RESET = 64'h0;
  localparam logic [NLF_W-1:0]  NLF_RESET     = 32'h3A5C742E;

  // Normal learning: serial bits kept, then tagged with top nibble 2 or 6
  localparam logic [WORD_W-1:0] SERIAL_MASK   = 32'h0FFF_FFFF;
  localparam logic [WORD_W-1:0] LEARN_LO_TAG  = 32'h2000_0000;
  localparam logic [WORD_W-1:0] LEARN_HI_TAG  = 32'h6000_0000;

  // Control that travels with a word down the chain
  typedef struct packed {
    logic      valid;
    req_type_t mode;
  } kcu_tag_t;

endpackage : kcu_pkg

`default_nettype wire

>>> src/kcu_round_cell.sv
// One KeeLoq round cell: two 32-bit lanes, registered, handed to the next cell.
`default_nettype none

module kcu_round_cell
  import kcu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire kcu_tag_t          prv_tag,
  input  wire logic [WORD_W-1:0] prv_lane_a,
  input  wire logic [WORD_W-1:0] prv_lane_b,
  input  wire logic [NLF_W-1:0]  nlf_table,
  input  wire logic              key_enc_bit,
  input  wire logic              key_dec_bit,
  output kcu_tag_t               tag,
  output logic [WORD_W-1:0]      lane_a,
  output logic [WORD_W-1:0]      lane_b
);

  kcu_tag_t          tag_r;
  logic [WORD_W-1:0] lane_a_r, lane_a_nxt;
  logic [WORD_W-1:0] lane_b_r, lane_b_nxt;

  function automatic logic [WORD_W-1:0] enc_round(input logic [WORD_W-1:0] x,
                                                  input logic [NLF_W-1:0] nlf,
                                                  input logic kb);
    logic [4:0] idx;
    logic       fb;
    idx = {x[31], x[26], x[20], x[9], x[1]};
    fb  = x[0] ^ x[16] ^ kb ^ nlf[idx];
    return {fb, x[WORD_W-1:1]};
  endfunction

  function automatic logic [WORD_W-1:0] dec_round(input logic [WORD_W-1:0] x,
                                                  input logic [NLF_W-1:0] nlf,
                                                  input logic kb);
    logic [4:0] idx;
    logic       fb;
    idx = {x[30], x[25], x[19], x[8], x[0]};
    fb  = x[31] ^ x[15] ^ kb ^ nlf[idx];
    return {x[WORD_W-2:0], fb};
  endfunction

  always_comb begin
    if (prv_tag.mode == REQ_ENCRYPT) begin
      lane_a_nxt = enc_round(prv_lane_a, nlf_table, key_enc_bit);
    end else begin
      lane_a_nxt = dec_round(prv_lane_a, nlf_table, key_dec_bit);
    end
    // lane b only matters for normal learning, always decrypts
    lane_b_nxt = dec_round(prv_lane_b, nlf_table, key_dec_bit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
      tag_r.mode  <= REQ_ENCRYPT;
    end else if (adv) begin
      tag_r <= prv_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_a_r <= lane_a_nxt;
      lane_b_r <= lane_b_nxt;
    end
  end

  assign tag    = tag_r;
  assign lane_a = lane_a_r;
  assign lane_b = lane_b_r;

endmodule : kcu_round_cell

`default_nettype wire

>>> src/keeloq_cipher_unit.sv
// Top level of the KeeLoq cipher unit: config registers, round-cell chain, output register.
`default_nettype none

// KeeLoq encrypt / decrypt / normal-learning unit. A word enters the chain of
// ROUNDS round cells (one round per cell). The first cell loads at the accepting
// edge, and the word then passes cell by cell to the output register, which
// drives out_tvalid. A new word is taken every cycle while the chain is not
// stalled. Each cell carries two lanes so the two decryptions of normal
// learning run side by side. The chain stalls only when the output register
// holds an untaken result and the last cell also holds a word. Key and
// nonlinear table are read live by all cells, so they are to be written while
// no word is in flight.

module keeloq_cipher_unit
  import kcu_pkg::*;
#(
  parameter int ROUNDS = 528
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [KEY_W-1:0]  cfg_wdata,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [31:0]       in_tdata,   // [31:0] data_word
  input  wire logic [1:0]        in_tuser,   // [1:0] req_type
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [63:0]            out_tdata   // [63:0] result_word
);

  logic [KEY_W-1:0]  mfr_key_r;
  logic [NLF_W-1:0]  nlf_r;

  kcu_tag_t          tag_s    [0:ROUNDS];
  logic [WORD_W-1:0] lane_a_s [0:ROUNDS];
  logic [WORD_W-1:0] lane_b_s [0:ROUNDS];

  logic              adv;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_data_r;
  req_type_t         out_mode_r;
  logic [63:0]       res_nxt;
  logic [WORD_W-1:0] serial;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mfr_key_r <= MFR_KEY_RESET;
      nlf_r     <= NLF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MFR_KEY: mfr_key_r <= cfg_wdata;
        CFG_NLF:     nlf_r     <= cfg_wdata[NLF_W-1:0];
        default:     ;
      endcase
    end
  end

  // chain moves unless the output is held and the last cell is occupied
  assign adv       = !out_valid_r || out_tready || !tag_s[ROUNDS].valid;
  assign in_tready = adv;

  // word formatting at the head of the chain
  assign serial = in_tdata & SERIAL_MASK;

  assign tag_s[0]    = kcu_tag_t'{valid: in_tvalid, mode: req_type_t'(in_tuser)};
  assign lane_a_s[0] = (req_type_t'(in_tuser) == REQ_LEARN) ? (serial | LEARN_LO_TAG)
                                                             : in_tdata;
  assign lane_b_s[0] = serial | LEARN_HI_TAG;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_cell
    localparam int KE = r & (KEY_W - 1);
    localparam int KD = (15 - r) & (KEY_W - 1);

    kcu_round_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .prv_tag     (tag_s[r]),
      .prv_lane_a  (lane_a_s[r]),
      .prv_lane_b  (lane_b_s[r]),
      .nlf_table   (nlf_r),
      .key_enc_bit (mfr_key_r[KE]),
      .key_dec_bit (mfr_key_r[KD]),
      .tag         (tag_s[r+1]),
      .lane_a      (lane_a_s[r+1]),
      .lane_b      (lane_b_s[r+1])
    );
  end

  // result assembly from the last cell
  always_comb begin
    unique case (tag_s[ROUNDS].mode)
      REQ_ENCRYPT, REQ_DECRYPT: res_nxt = {32'h0, lane_a_s[ROUNDS]};
      REQ_LEARN:                res_nxt = {lane_b_s[ROUNDS], lane_a_s[ROUNDS]};
      default:                  res_nxt = 64'h0;
    endcase
  end

  always_comb begin
    if (out_valid_r && !out_tready) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = tag_s[ROUNDS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!(out_valid_r && !out_tready) && tag_s[ROUNDS].valid) begin
      out_data_r <= res_nxt;
      out_mode_r <= tag_s[ROUNDS].mode;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // an accepted word lands in the first cell
  a_head_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> tag_s[1].valid)
    else $error("accepted word missing from first cell");

  // a word in the last cell is never dropped while the chain is held
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && tag_s[ROUNDS].valid |=> tag_s[ROUNDS].valid && out_tvalid)
    else $error("word lost from last cell during stall");

  // high half is nonzero only for normal learning
  a_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_mode_r != REQ_LEARN |-> out_tdata[63:32] == 32'h0)
    else $error("high half set outside normal learning");

  // reserved request gives zero
  a_rsvd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_mode_r == REQ_RSVD |-> out_tdata == 64'h0)
    else $error("reserved request gave nonzero result");
`endif

endmodule : keeloq_cipher_unit

`default_nettype wire

>>> sim/keeloq_cipher_unit_test.sv
// Self-checking testbench for the KeeLoq cipher unit: directed table, then random words.
`default_nettype none

module keeloq_cipher_unit_test;
  import kcu_pkg::*;

  localparam int ROUNDS      = 528;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 192;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS    = 18;

  typedef struct packed {
    req_type_t   kind;
    logic [31:0] word;
    logic        typed;   // want holds the expected result as written
    logic [63:0] want;
  } dir_row_t;

  // Reserved selector always yields zero; everything else goes to the predictor.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{REQ_ENCRYPT, 32'h0000_0000, 1'b0, 64'h0},
    '{REQ_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 64'h0},
    '{REQ_ENCRYPT, 32'h0000_0001, 1'b0, 64'h0},
    '{REQ_ENCRYPT, 32'h8000_0000, 1'b0, 64'h0},
    '{REQ_ENCRYPT, 32'h5A5A_5A5A, 1'b0, 64'h0},
    '{REQ_DECRYPT, 32'h0000_0000, 1'b0, 64'h0},
    '{REQ_DECRYPT, 32'hFFFF_FFFF, 1'b0, 64'h0},
    '{REQ_DECRYPT, 32'h0000_0001, 1'b0, 64'h0},
    '{REQ_DECRYPT, 32'h8000_0000, 1'b0, 64'h0},
    '{REQ_DECRYPT, 32'hA5A5_A5A5, 1'b0, 64'h0},
    '{REQ_LEARN,   32'h0000_0000, 1'b0, 64'h0},
    '{REQ_LEARN,   32'hFFFF_FFFF, 1'b0, 64'h0},
    '{REQ_LEARN,   32'h0FFF_FFFF, 1'b0, 64'h0},
    '{REQ_LEARN,   32'hF000_0000, 1'b0, 64'h0},  // serial top nibble must be ignored
    '{REQ_LEARN,   32'h1234_5678, 1'b0, 64'h0},
    '{REQ_RSVD,    32'h0000_0000, 1'b1, 64'h0},
    '{REQ_RSVD,    32'hFFFF_FFFF, 1'b1, 64'h0},
    '{REQ_RSVD,    32'h1357_9BDF, 1'b1, 64'h0}
  };

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = 1'b0;
  logic [KEY_W-1:0]  cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata   = '0;   // [31:0] data_word
  logic [1:0]        in_tuser   = '0;   // [1:0] req_type
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;         // [63:0] result_word

  // Sender-side tag for the word on the bus
  logic              row_typed  = 1'b0;
  logic [63:0]       row_want   = '0;

  // Predictor copy of the register file
  logic [63:0]       mfr_key    = MFR_KEY_RESET;
  logic [31:0]       nlf_tab    = NLF_RESET;

  logic [63:0]       pending_results [$];
  logic [63:0]       want_now;
  bit                idle_on    = 1'b1;
  int                stall_left = 0;
  int                errors     = 0;
  int                accepted   = 0;
  int                checked    = 0;
  int                cycles     = 0;
  int                kind_cnt [4];
  int                key_sets   = 0;

  keeloq_cipher_unit #(.ROUNDS(ROUNDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] kl_forward(logic [31:0] x);
    logic [4:0] idx;
    logic       fb;
    for (int r = 0; r < ROUNDS; r++) begin
      idx = {x[31], x[26], x[20], x[9], x[1]};
      fb  = x[0] ^ x[16] ^ mfr_key[r % 64] ^ nlf_tab[idx];
      x   = {fb, x[31:1]};
    end
    return x;
  endfunction

  function automatic logic [31:0] kl_inverse(logic [31:0] x);
    logic [4:0] idx;
    logic       fb;
    int         kpos;
    for (int r = 0; r < ROUNDS; r++) begin
      idx  = {x[30], x[25], x[19], x[8], x[0]};
      kpos = (15 - r) & 63;   // key walks backward, wrapping mod 64
      fb   = x[31] ^ x[15] ^ mfr_key[kpos] ^ nlf_tab[idx];
      x    = {x[30:0], fb};
    end
    return x;
  endfunction

  function automatic logic [63:0] predict_result(req_type_t kind, logic [31:0] w);
    logic [31:0] serial;
    serial = w & SERIAL_MASK;
    case (kind)
      REQ_ENCRYPT: return {32'h0, kl_forward(w)};
      REQ_DECRYPT: return {32'h0, kl_inverse(w)};
      REQ_LEARN:   return {kl_inverse(serial | LEARN_HI_TAG), kl_inverse(serial | LEARN_LO_TAG)};
      default:     return 64'h0;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Leaves tvalid high after the accepting edge; the next call decides whether it drops.
  task automatic send_word(req_type_t kind, logic [31:0] w, logic typed, logic [63:0] want);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= w;
    row_typed <= typed;
    row_want  <= want;
    kind_cnt[kind]++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_keys(logic [63:0] k, logic [31:0] t);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MFR_KEY;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_index <= CFG_NLF;
    cfg_wdata <= {32'h0, t};
    @(posedge clk);
    cfg_we    <= 1'b0;
    mfr_key   = k;
    nlf_tab   = t;
    key_sets++;
  endtask

  // Receiver back-pressure in short bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (row_typed)
          pending_results.push_back(row_want);
        else
          pending_results.push_back(predict_result(req_type_t'(in_tuser), in_tdata));
        accepted++;
      end
      if (out_tvalid && out_tready) begin
        checked++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result word %h with nothing outstanding", out_tdata);
        end else begin
          want_now = pending_results.pop_front();
          if (out_tdata !== want_now) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: result_word expected %h got %h (result %0d)",
                       want_now, out_tdata, checked);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("keeloq_cipher_unit: mismatch");
      $finish;
    end
  end

  initial begin
    req_type_t kind;
    int        pick;
    for (int i = 0; i < 4; i++) kind_cnt[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run under the reset key and table
    for (int i = 0; i < DIR_ROWS; i++)
      send_word(DIR_TAB[i].kind, DIR_TAB[i].word, DIR_TAB[i].typed, DIR_TAB[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        wait_drained();
        case (ph)
          1:       set_keys(64'h0, 32'h0);
          2:       set_keys({64{1'b1}}, 32'hFFFF_FFFF);
          3:       set_keys({64{1'b1}}, NLF_RESET);
          4, 7:    set_keys({$urandom, $urandom}, NLF_RESET);
          default: set_keys({$urandom, $urandom}, $urandom);
        endcase
      end
      idle_on = !(ph == 4 || ph == PHASES - 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 5 && n == PHASE_WORDS / 2) wait_drained();
        pick = $urandom_range(0, 15);
        kind = (pick == 15) ? REQ_RSVD : req_type_t'(pick % 3);
        send_word(kind, pick_word(), 1'b0, 64'h0);
      end
    end

    wait_drained();
    repeat (ROUNDS + 20) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("ERROR: %0d results never arrived", pending_results.size());
    end

    $display("Covered %0d words (encrypt %0d, decrypt %0d, learn %0d, reserved %0d)",
             accepted, kind_cnt[REQ_ENCRYPT], kind_cnt[REQ_DECRYPT], kind_cnt[REQ_LEARN],
             kind_cnt[REQ_RSVD]);
    $display("%0d results checked across %0d key/table settings plus reset values",
             checked, key_sets);
    if (errors == 0) begin
      $display("keeloq_cipher_unit: match");
    end else begin
      $display("keeloq_cipher_unit: mismatch");
    end
    $finish;
  end

endmodule : keeloq_cipher_unit_test

`default_nettype wire

>>> keeloq_cipher_unit.f
src/kcu_pkg.sv
src/kcu_round_cell.sv
src/keeloq_cipher_unit.sv
sim/keeloq_cipher_unit_test.sv
